>>> src/spq_pkg.sv
// Package for the stable priority queue: field widths, command codes,
// entry and beat types. No dependencies.
`default_nettype none

package spq_pkg;

  localparam int ID_BITS      = 8;
  localparam int PRIO_BITS    = 3;
  localparam int COUNT_BITS   = 5;
  localparam int DEF_CAPACITY = 16;

  localparam logic [1:0] KIND_PUSH_ORD  = 2'd0;
  localparam logic [1:0] KIND_PUSH_HEAD = 2'd1;
  localparam logic [1:0] KIND_POP       = 2'd2;

  typedef struct packed {
    logic [1:0]           kind;
    logic [ID_BITS-1:0]   thread_id;
    logic [PRIO_BITS-1:0] prio;
  } spq_cmd_t;

  typedef struct packed {
    logic                  head_valid;
    logic [ID_BITS-1:0]    head_thread;
    logic [PRIO_BITS-1:0]  head_prio;
    logic [ID_BITS-1:0]    popped_thread;
    logic [COUNT_BITS-1:0] entry_count;
    logic                  overflow;
    logic                  underflow;
  } spq_result_t;

  typedef struct packed {
    logic [ID_BITS-1:0]   thread;
    logic [PRIO_BITS-1:0] prio;
  } spq_entry_t;

  typedef struct packed {
    logic        done;
    spq_result_t res;
  } spq_evt_t;

endpackage

`default_nettype wire

>>> src/stable_priority_queue.sv
// Top level of the stable priority queue: sequencer, entry RAM, result register.
// Depends on spq_pkg, spq_ram, spq_ctrl.
//
//   channel   ports                      beat
//   command   start, busy, cmd_i         start & !busy
//   result    done_o, res_o              done_o (one cycle, no stall)
//
// Result appears the cycle after the last work cycle. Nop, rejected push or
// pop and head push finish in S_IDLE; pop finishes there too when it empties
// the queue, else in S_POP_WAIT (head reload from RAM). Ordered push does a
// read-then-write scan (S_SCAN_RD, S_SCAN_WR) over the single-read-port RAM.
// Reset empties the queue at once; the RAM is not cleared.
`default_nettype none

module stable_priority_queue import spq_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start,
  output      logic     busy,
  input  wire spq_cmd_t cmd_i,
  output      logic     done_o,
  output spq_result_t   res_o
);

  localparam int AW = $clog2(CAPACITY);

  spq_evt_t    evt;
  logic        ram_we;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  spq_entry_t  ram_wdata;
  spq_entry_t  ram_rdata;
  logic        done_q;
  spq_result_t res_q;

  spq_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd_i),
    .evt_o       (evt),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  spq_ram #(
    .WIDTH($bits(spq_entry_t)),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= evt.done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (evt.done) begin
      res_q <= evt.res;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire

>>> src/spq_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module spq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> src/spq_ctrl.sv
// Queue sequencer: circular entry store addressed through one shared modular
// address adder, head cache, scan/ripple insert loop. Uses spq_pkg.
`default_nettype none

module spq_ctrl import spq_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output      logic                        busy,
  input  wire spq_cmd_t                    cmd_i,
  output      spq_evt_t                    evt_o,
  output      logic                        ram_we_o,
  output      logic [$clog2(CAPACITY)-1:0] ram_waddr_o,
  output      spq_entry_t                  ram_wdata_o,
  output      logic [$clog2(CAPACITY)-1:0] ram_raddr_o,
  input  wire spq_entry_t                  ram_rdata_i
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_WR,
    S_POP_WAIT
  } state_e;

  state_e               state_q, state_d;
  logic [AW-1:0]        head_ptr_q, head_ptr_d;
  logic [CW-1:0]        count_q, count_d;
  logic [AW-1:0]        idx_q, idx_d;
  spq_entry_t           carry_q, carry_d;
  logic                 found_q, found_d;
  logic [PRIO_BITS-1:0] pr_q, pr_d;
  spq_entry_t           head_q, head_d;
  logic [ID_BITS-1:0]   popped_q, popped_d;

  logic [AW-1:0]        off;
  logic [AW:0]          sum;
  logic [AW-1:0]        phys;
  logic                 done;
  logic                 ovf;
  logic                 unf;
  logic [ID_BITS-1:0]   popped;
  spq_entry_t           new_ent;
  logic                 full;

  // shared modular address unit: head + offset mod CAPACITY
  always_comb begin
    sum  = {1'b0, head_ptr_q} + {1'b0, off};
    phys = (sum >= (AW+1)'(CAPACITY)) ? AW'(sum - (AW+1)'(CAPACITY)) : AW'(sum);
  end

  assign new_ent.thread = cmd_i.thread_id;
  assign new_ent.prio   = cmd_i.prio;
  assign full           = (count_q == CW'(CAPACITY));
  assign busy           = (state_q != S_IDLE);

  always_comb begin
    state_d    = state_q;
    head_ptr_d = head_ptr_q;
    count_d    = count_q;
    idx_d      = idx_q;
    carry_d    = carry_q;
    found_d    = found_q;
    pr_d       = pr_q;
    head_d     = head_q;
    popped_d   = popped_q;
    off        = idx_q;
    done       = 1'b0;
    ovf        = 1'b0;
    unf        = 1'b0;
    popped     = '0;
    ram_we_o    = 1'b0;
    ram_wdata_o = carry_q;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          case (cmd_i.kind)
            KIND_PUSH_ORD: begin
              if (full) begin
                ovf  = 1'b1;
                done = 1'b1;
              end else begin
                pr_d    = cmd_i.prio;
                carry_d = new_ent;
                found_d = 1'b0;
                idx_d   = '0;
                state_d = S_SCAN_RD;
              end
            end
            KIND_PUSH_HEAD: begin
              if (full) begin
                ovf  = 1'b1;
                done = 1'b1;
              end else begin
                off         = AW'(CAPACITY - 1);
                head_ptr_d  = phys;
                ram_we_o    = 1'b1;
                ram_wdata_o = new_ent;
                head_d      = new_ent;
                count_d     = count_q + CW'(1);
                done        = 1'b1;
              end
            end
            KIND_POP: begin
              if (count_q == '0) begin
                unf  = 1'b1;
                done = 1'b1;
              end else begin
                off        = AW'(1);
                head_ptr_d = phys;
                count_d    = count_q - CW'(1);
                popped_d   = head_q.thread;
                if (count_q == CW'(1)) begin
                  popped = head_q.thread;
                  done   = 1'b1;
                end else begin
                  state_d = S_POP_WAIT;
                end
              end
            end
            default: begin
              done = 1'b1;
            end
          endcase
        end
      end
      S_SCAN_RD: begin
        if (CW'(idx_q) == count_q) begin
          ram_we_o = 1'b1;
          if (idx_q == '0) begin
            head_d = carry_q;
          end
          count_d = count_q + CW'(1);
          done    = 1'b1;
          state_d = S_IDLE;
        end else begin
          state_d = S_SCAN_WR;
        end
      end
      S_SCAN_WR: begin
        if (found_q || (ram_rdata_i.prio < pr_q)) begin
          ram_we_o = 1'b1;
          if (idx_q == '0) begin
            head_d = carry_q;
          end
          carry_d = ram_rdata_i;
          found_d = 1'b1;
        end
        idx_d   = idx_q + AW'(1);
        state_d = S_SCAN_RD;
      end
      S_POP_WAIT: begin
        head_d  = ram_rdata_i;
        popped  = popped_q;
        done    = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign ram_waddr_o = phys;
  assign ram_raddr_o = phys;

  always_comb begin
    evt_o.done              = done;
    evt_o.res.head_valid    = (count_d != '0);
    evt_o.res.head_thread   = (count_d != '0) ? head_d.thread : '0;
    evt_o.res.head_prio     = (count_d != '0) ? head_d.prio : '0;
    evt_o.res.popped_thread = popped;
    evt_o.res.entry_count   = COUNT_BITS'(count_d);
    evt_o.res.overflow      = ovf;
    evt_o.res.underflow     = unf;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      head_ptr_q <= '0;
      count_q    <= '0;
      idx_q      <= '0;
      found_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      head_ptr_q <= head_ptr_d;
      count_q    <= count_d;
      idx_q      <= idx_d;
      found_q    <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    carry_q  <= carry_d;
    pr_q     <= pr_d;
    head_q   <= head_d;
    popped_q <= popped_d;
  end

endmodule

`default_nettype wire

>>> dv/spq_checker.sv
// Scoreboard for the stable priority queue: keeps its own copy of the queue,
// predicts the status beat of every accepted command and compares it.
// Depends on spq_pkg.
`default_nettype none

module spq_checker import spq_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire spq_cmd_t    cmd_i,
  input  wire logic        done_i,
  input  wire spq_result_t res_i,
  output      int          fail_count_o,
  output      int          pending_o,
  output      int          checked_o,
  output      int          overflow_seen_o,
  output      int          underflow_seen_o
);

  spq_entry_t  slots [CAPACITY];
  int          held;
  spq_result_t status_due [$];

  // Applies one command to the shadow queue and returns the status it reports.
  function automatic spq_result_t queue_step(spq_cmd_t c);
    spq_result_t r;
    int pos;
    r = '0;
    if (c.kind == KIND_PUSH_ORD || c.kind == KIND_PUSH_HEAD) begin
      if (held >= CAPACITY) begin
        r.overflow = 1'b1;
      end else begin
        pos = 0;
        if (c.kind == KIND_PUSH_ORD) begin
          pos = held;
          for (int i = 0; i < held; i++) begin
            if (slots[i].prio < c.prio) begin
              pos = i;
              break;
            end
          end
        end
        for (int i = held; i > pos; i--) slots[i] = slots[i-1];
        slots[pos].thread = c.thread_id;
        slots[pos].prio   = c.prio;
        held++;
      end
    end else if (c.kind == KIND_POP) begin
      if (held == 0) begin
        r.underflow = 1'b1;
      end else begin
        r.popped_thread = slots[0].thread;
        for (int i = 1; i < held; i++) slots[i-1] = slots[i];
        held--;
      end
    end
    if (held != 0) begin
      r.head_valid  = 1'b1;
      r.head_thread = slots[0].thread;
      r.head_prio   = slots[0].prio;
    end
    r.entry_count = COUNT_BITS'(held);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    spq_result_t want;
    if (!rst_ni) begin
      held = 0;
      status_due.delete();
      fail_count_o = 0;
      pending_o = 0;
      checked_o = 0;
      overflow_seen_o = 0;
      underflow_seen_o = 0;
    end else begin
      if (done_i) begin
        if (status_due.size() == 0) begin
          $display("%0t: status beat with none expected: %p", $time, res_i);
          fail_count_o++;
        end else begin
          want = status_due.pop_front();
          checked_o++;
          if (res_i.overflow)  overflow_seen_o++;
          if (res_i.underflow) underflow_seen_o++;
          if (res_i.head_valid !== want.head_valid) begin
            $display("%0t: head_valid exp %0d got %0d", $time, want.head_valid,
                     res_i.head_valid);
            fail_count_o++;
          end
          if (res_i.head_thread !== want.head_thread) begin
            $display("%0t: head_thread exp %0d got %0d", $time, want.head_thread,
                     res_i.head_thread);
            fail_count_o++;
          end
          if (res_i.head_prio !== want.head_prio) begin
            $display("%0t: head_prio exp %0d got %0d", $time, want.head_prio,
                     res_i.head_prio);
            fail_count_o++;
          end
          if (res_i.popped_thread !== want.popped_thread) begin
            $display("%0t: popped_thread exp %0d got %0d", $time, want.popped_thread,
                     res_i.popped_thread);
            fail_count_o++;
          end
          if (res_i.entry_count !== want.entry_count) begin
            $display("%0t: entry_count exp %0d got %0d", $time, want.entry_count,
                     res_i.entry_count);
            fail_count_o++;
          end
          if (res_i.overflow !== want.overflow) begin
            $display("%0t: overflow exp %0d got %0d", $time, want.overflow,
                     res_i.overflow);
            fail_count_o++;
          end
          if (res_i.underflow !== want.underflow) begin
            $display("%0t: underflow exp %0d got %0d", $time, want.underflow,
                     res_i.underflow);
            fail_count_o++;
          end
        end
      end
      if (start && !busy) status_due.push_back(queue_step(cmd_i));
      pending_o = status_due.size();
    end
  end

endmodule

`default_nettype wire

>>> dv/stable_priority_queue_test.sv
// Testbench top for the stable priority queue: clock, reset, command stimulus
// in bursts with gaps, and the verdict. Depends on spq_pkg, stable_priority_queue, spq_checker.
`default_nettype none

module stable_priority_queue_test;
  import spq_pkg::*;

  localparam int         CAPACITY   = DEF_CAPACITY;
  localparam int         RAND_ITEMS = 700;
  localparam int         CYCLE_CAP  = 400000;
  localparam logic [1:0] KIND_NOP   = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  spq_cmd_t    cmd = '0;
  logic        busy;
  logic        done;
  spq_result_t res;
  int          fails, pending, checked, ovf_seen, unf_seen;
  int          cycles = 0;

  stable_priority_queue #(.CAPACITY(CAPACITY)) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .start (start),
    .busy  (busy),
    .cmd_i (cmd),
    .done_o(done),
    .res_o (res)
  );

  spq_checker #(.CAPACITY(CAPACITY)) chk (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .start           (start),
    .busy            (busy),
    .cmd_i           (cmd),
    .done_i          (done),
    .res_i           (res),
    .fail_count_o    (fails),
    .pending_o       (pending),
    .checked_o       (checked),
    .overflow_seen_o (ovf_seen),
    .underflow_seen_o(unf_seen)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d beats outstanding", cycles, pending);
      $display("FAIL stable_priority_queue");
      $finish;
    end
  end

  function automatic spq_cmd_t mk_cmd(logic [1:0] k, logic [ID_BITS-1:0] id,
                                      logic [PRIO_BITS-1:0] p);
    spq_cmd_t c;
    c.kind      = k;
    c.thread_id = id;
    c.prio      = p;
    return c;
  endfunction

  // Push-heavy stretches fill the queue to overflow, pop-heavy ones drain it.
  function automatic spq_cmd_t random_cmd(bit fill_heavy);
    int r;
    logic [1:0] k;
    r = $urandom_range(0, 99);
    if (r < 3)
      k = KIND_NOP;
    else if (r < (fill_heavy ? 78 : 28))
      k = ($urandom_range(0, 3) == 0) ? KIND_PUSH_HEAD : KIND_PUSH_ORD;
    else
      k = KIND_POP;
    return mk_cmd(k, ID_BITS'($urandom), PRIO_BITS'($urandom));
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat.
  task automatic send_beat(input spq_cmd_t c);
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic idle_for(input int n);
    start <= 1'b0;
    cmd   <= spq_cmd_t'($urandom);
    repeat (n) @(negedge clk);
  endtask

  task automatic wait_drain();
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    int  sent;
    int  burst_len;
    int  stretch;
    bit  fill_heavy;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: empty queue, fill to capacity with ties, overflow, then pops
    send_beat(mk_cmd(KIND_POP, 8'hff, 3'd7));
    send_beat(mk_cmd(KIND_NOP, 8'h5a, 3'd2));
    for (int i = 0; i < CAPACITY; i++) begin
      send_beat(mk_cmd((i % 5 == 2) ? KIND_PUSH_HEAD : KIND_PUSH_ORD,
                       ID_BITS'(i * 17), PRIO_BITS'((i * 5) % 8)));
      if (i % 4 == 3) idle_for(i % 3);
    end
    send_beat(mk_cmd(KIND_PUSH_ORD, 8'h00, 3'd7));
    send_beat(mk_cmd(KIND_PUSH_HEAD, 8'hff, 3'd0));
    send_beat(mk_cmd(KIND_NOP, 8'hff, 3'd7));
    send_beat(mk_cmd(KIND_POP, 8'h00, 3'd0));
    send_beat(mk_cmd(KIND_POP, 8'h00, 3'd0));
    wait_drain();

    sent = 0;
    stretch = $urandom_range(10, 40);
    fill_heavy = 1'b1;
    while (sent < RAND_ITEMS) begin
      burst_len = $urandom_range(1, 12);
      repeat (burst_len) begin
        send_beat(random_cmd(fill_heavy));
        sent++;
        stretch--;
        if (stretch <= 0) begin
          fill_heavy = !fill_heavy;
          stretch = $urandom_range(10, 40);
        end
      end
      case ($urandom_range(0, 9))
        0, 1, 2: ;
        3: wait_drain();
        default: idle_for($urandom_range(1, 6));
      endcase
    end

    wait_drain();
    repeat (40) @(negedge clk);
    $display("%0d commands sent, %0d status beats checked", sent + 2 * CAPACITY / 2 + 7,
             checked);
    $display("overflow hits %0d, underflow hits %0d", ovf_seen, unf_seen);
    if (fails == 0 && pending == 0)
      $display("PASS stable_priority_queue");
    else
      $display("FAIL stable_priority_queue");
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
src/spq_pkg.sv
src/spq_ram.sv
src/spq_ctrl.sv
src/stable_priority_queue.sv
dv/spq_checker.sv
dv/stable_priority_queue_test.sv
